@@ design/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared sizes, controller states and the command and status words for the
// strongly connected component rank histogram block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int MaxNodes  = 64;
  localparam int MaxEdges  = 1024;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CountW    = $clog2(MaxNodes + 1);
  localparam int EdgeAw    = $clog2(MaxEdges);
  localparam int EdgeCntW  = $clog2(MaxEdges + 1);
  localparam int RankW     = 6;
  localparam int TotalW    = 7;
  localparam int EdgeWordW = 2 * NodeW;
  localparam int NodeRowW  = MaxNodes + RankW;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_E_RD,
    ST_E_CHK,
    ST_N_UPD,
    ST_H_RD,
    ST_H_TOT,
    ST_H_UPD,
    ST_O_RD,
    ST_O_LOAD,
    ST_O_SEND
  } state_e;

  typedef struct packed {
    logic load_edge;
    logic idx_clr;
    logic idx_inc;
    logic clr_wr;
    logic e_clr;
    logic e_inc;
    logic chg_clr;
    logic phase_rank;
    logic edge_chk;
    logic node_upd;
    logic node_by_idx;
    logic hist_tot;
    logic hist_upd;
    logic out_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pass_end;
    logic edge_ok;
    logic changed;
    logic idx_at_n;
    logic idx_last;
    logic out_last;
  } stat_t;

endpackage

@@ design/scc_condense_rank_histogram_top.sv @@
// ----------------------------------------------------------------------------
// scc_condense_rank_histogram_top
// Loads directed edges, finds strongly connected components, ranks them by
// longest path in the condensation and emits node totals per rank.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                      | word
//  ---------+-----------+--------------------------------+------------------------
//  edge     | in        | edge_valid_i / edge_ready_o    | source, target, last
//  result   | out       | result_valid_o / result_ready_i| rank, total, last, drop
//  cfg      | in        | cfg_valid_i / cfg_ready_o      | node count
//
//  edges are taken one per cycle while loading, in-range ones into the edge ram
//  after the last edge: a clearing sweep of every node and total ram entry,
//  then closure passes and rank passes that read and check each stored edge
//  and update the node ram for an edge in range, then close the pass, each kind
//  repeated until a pass makes no change, then the histogram reads, totals and
//  updates per node, then each rank word is read, loaded and sent, any result
//  stall holding the send; the edge ram read loop sets the pass cost
//  no edge word is taken from the last edge until the final result word goes
//  reset is asynchronous, active low, and leaves the block loading
module scc_condense_rank_histogram_top import scc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_node_count_i,
  input  logic              edge_valid_i,
  output logic              edge_ready_o,
  input  logic [NodeW-1:0]  edge_source_i,
  input  logic [NodeW-1:0]  edge_target_i,
  input  logic              last_edge_i,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic [RankW-1:0]  rank_o,
  output logic [TotalW-1:0] node_total_o,
  output logic              last_rank_o,
  output logic              edges_dropped_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  scc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .edge_valid_i   (edge_valid_i),
    .edge_ready_o   (edge_ready_o),
    .last_edge_i    (last_edge_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // storage and arithmetic
  scc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_node_count_i (cfg_node_count_i),
    .edge_source_i    (edge_source_i),
    .edge_target_i    (edge_target_i),
    .rank_o           (rank_o),
    .node_total_o     (node_total_o),
    .last_rank_o      (last_rank_o),
    .edges_dropped_o  (edges_dropped_o)
  );

endmodule

@@ design/scc_ram.sv @@
// ----------------------------------------------------------------------------
// scc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ design/scc_datapath.sv @@
// ----------------------------------------------------------------------------
// scc_datapath
// Edge store, per-node reach rows and ranks, rank totals, counters and the
// result register.
// ----------------------------------------------------------------------------
module scc_datapath import scc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_node_count_i,
  input  logic [NodeW-1:0]    edge_source_i,
  input  logic [NodeW-1:0]    edge_target_i,
  output logic [RankW-1:0]    rank_o,
  output logic [TotalW-1:0]   node_total_o,
  output logic                last_rank_o,
  output logic                edges_dropped_o
);

  logic [CountW-1:0]   node_count_q, n_used;
  logic [EdgeCntW-1:0] edge_total_q, e_q;
  logic                drop_q, changed_q;
  logic [CountW-1:0]   idx_q;
  logic [RankW-1:0]    max_q;
  logic                in_ok, store_we;
  logic [EdgeWordW-1:0] edge_rd;
  logic [NodeW-1:0]    es, et;
  logic                eok;
  logic [NodeRowW-1:0] rd_a, rd_b, node_wdata;
  logic [NodeW-1:0]    node_ra, node_wa, tot_ra, tot_wa;
  logic                node_we, tot_we;
  logic [MaxNodes-1:0] row_a, row_b, new_row;
  logic [RankW-1:0]    rank_a, rank_b, cand;
  logic [TotalW-1:0]   tot_rd, tot_wdata;
  logic                upd_we;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (node_count_q == '0) begin
      n_used = CountW'(1);
    end else if (node_count_q > CountW'(MaxNodes)) begin
      n_used = CountW'(MaxNodes);
    end else begin
      n_used = node_count_q;
    end
  end

  assign in_ok = (CountW'(edge_source_i) < n_used) && (CountW'(edge_target_i) < n_used)
                 && (edge_total_q < EdgeCntW'(MaxEdges));
  assign store_we = cmd_i.load_edge && in_ok;

  scc_ram #(.Width(EdgeWordW), .Depth(MaxEdges)) u_edge_ram (
    .clk_i     (clk_i),
    .we_i      (store_we),
    .waddr_i   (edge_total_q[EdgeAw-1:0]),
    .wdata_i   ({edge_source_i, edge_target_i}),
    .raddr_a_i (e_q[EdgeAw-1:0]),
    .raddr_b_i (e_q[EdgeAw-1:0]),
    .rdata_a_o (edge_rd),
    .rdata_b_o ()
  );

  assign es  = edge_rd[EdgeWordW-1:NodeW];
  assign et  = edge_rd[NodeW-1:0];
  assign eok = (CountW'(es) < n_used) && (CountW'(et) < n_used);

  assign row_a  = rd_a[NodeRowW-1:RankW];
  assign rank_a = rd_a[RankW-1:0];
  assign row_b  = rd_b[NodeRowW-1:RankW];
  assign rank_b = rd_b[RankW-1:0];

  // reach closure and rank relaxation for the current edge
  assign new_row = row_a | row_b | (MaxNodes'(1) << et);
  assign cand    = row_b[es] ? rank_a : rank_a + RankW'(1);
  assign upd_we  = cmd_i.phase_rank ? (cand > rank_b) : (new_row != row_a);

  assign node_ra = cmd_i.node_by_idx ? idx_q[NodeW-1:0] : es;

  always_comb begin
    node_we    = 1'b0;
    node_wa    = idx_q[NodeW-1:0];
    node_wdata = '0;
    if (cmd_i.clr_wr) begin
      node_we = 1'b1;
    end else if (cmd_i.node_upd) begin
      node_we = upd_we;
      if (cmd_i.phase_rank) begin
        node_wa    = et;
        node_wdata = {row_b, cand};
      end else begin
        node_wa    = es;
        node_wdata = {new_row, rank_a};
      end
    end
  end

  scc_ram #(.Width(NodeRowW), .Depth(MaxNodes)) u_node_ram (
    .clk_i     (clk_i),
    .we_i      (node_we),
    .waddr_i   (node_wa),
    .wdata_i   (node_wdata),
    .raddr_a_i (node_ra),
    .raddr_b_i (et),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign tot_ra    = cmd_i.hist_tot ? rank_a : idx_q[NodeW-1:0];
  assign tot_we    = cmd_i.clr_wr || cmd_i.hist_upd;
  assign tot_wa    = cmd_i.clr_wr ? idx_q[NodeW-1:0] : rank_a;
  assign tot_wdata = cmd_i.clr_wr ? '0 : tot_rd + TotalW'(1);

  scc_ram #(.Width(TotalW), .Depth(MaxNodes)) u_total_ram (
    .clk_i     (clk_i),
    .we_i      (tot_we),
    .waddr_i   (tot_wa),
    .wdata_i   (tot_wdata),
    .raddr_a_i (tot_ra),
    .raddr_b_i (tot_ra),
    .rdata_a_o (tot_rd),
    .rdata_b_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountW'(MaxNodes);
      edge_total_q <= '0;
      drop_q       <= 1'b0;
      changed_q    <= 1'b0;
      e_q          <= '0;
      idx_q        <= '0;
      max_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= cfg_node_count_i;
      end
      if (cmd_i.load_edge) begin
        if (in_ok) begin
          edge_total_q <= edge_total_q + EdgeCntW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.edge_chk && !eok) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        edge_total_q <= '0;
        drop_q       <= 1'b0;
      end
      if (cmd_i.chg_clr) begin
        changed_q <= 1'b0;
      end else if (cmd_i.node_upd && upd_we) begin
        changed_q <= 1'b1;
      end
      if (cmd_i.e_clr) begin
        e_q <= '0;
      end else if (cmd_i.e_inc) begin
        e_q <= e_q + EdgeCntW'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CountW'(1);
      end
      if (cmd_i.clr_wr) begin
        max_q <= '0;
      end else if (cmd_i.hist_upd && rank_a > max_q) begin
        max_q <= rank_a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rank_o          <= idx_q[RankW-1:0];
      node_total_o    <= tot_rd;
      last_rank_o     <= (idx_q[RankW-1:0] == max_q);
      edges_dropped_o <= drop_q;
    end
  end

  assign stat_o.pass_end = (e_q == edge_total_q);
  assign stat_o.edge_ok  = eok;
  assign stat_o.changed  = changed_q;
  assign stat_o.idx_at_n = (idx_q == n_used);
  assign stat_o.idx_last = (idx_q == CountW'(MaxNodes - 1));
  assign stat_o.out_last = last_rank_o;

endmodule

@@ design/scc_ctrl.sv @@
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: edge loading, clearing sweep, closure and rank passes,
// histogram build and result emission.
// ----------------------------------------------------------------------------
module scc_ctrl import scc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  edge_valid_i,
  output logic  edge_ready_o,
  input  logic  last_edge_i,
  output logic  result_valid_o,
  input  logic  result_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    cmd_o          = '0;
    cmd_o.phase_rank = phase_q;
    edge_ready_o   = 1'b0;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        edge_ready_o = 1'b1;
        if (edge_valid_i) begin
          cmd_o.load_edge = 1'b1;
          if (last_edge_i) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.idx_inc = 1'b1;
        if (stat_i.idx_last) begin
          cmd_o.e_clr   = 1'b1;
          cmd_o.chg_clr = 1'b1;
          phase_d       = 1'b0;
          state_d       = ST_E_RD;
        end
      end
      ST_E_RD: begin
        if (stat_i.pass_end) begin
          cmd_o.e_clr   = 1'b1;
          cmd_o.chg_clr = 1'b1;
          if (!stat_i.changed) begin
            if (!phase_q) begin
              phase_d = 1'b1;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = ST_H_RD;
            end
          end
        end else begin
          state_d = ST_E_CHK;
        end
      end
      ST_E_CHK: begin
        cmd_o.edge_chk = 1'b1;
        if (stat_i.edge_ok) begin
          state_d = ST_N_UPD;
        end else begin
          cmd_o.e_inc = 1'b1;
          state_d     = ST_E_RD;
        end
      end
      ST_N_UPD: begin
        cmd_o.node_upd = 1'b1;
        cmd_o.e_inc    = 1'b1;
        state_d        = ST_E_RD;
      end
      ST_H_RD: begin
        cmd_o.node_by_idx = 1'b1;
        if (stat_i.idx_at_n) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_O_RD;
        end else begin
          state_d = ST_H_TOT;
        end
      end
      ST_H_TOT: begin
        cmd_o.node_by_idx = 1'b1;
        cmd_o.hist_tot    = 1'b1;
        state_d           = ST_H_UPD;
      end
      ST_H_UPD: begin
        cmd_o.node_by_idx = 1'b1;
        cmd_o.hist_upd    = 1'b1;
        cmd_o.idx_inc     = 1'b1;
        state_d           = ST_H_RD;
      end
      ST_O_RD: begin
        state_d = ST_O_LOAD;
      end
      ST_O_LOAD: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_O_SEND;
      end
      ST_O_SEND: begin
        result_valid_o = 1'b1;
        if (result_ready_i) begin
          if (stat_i.out_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_O_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

@@ design/scc_checker.sv @@
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks on the rank histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module scc_checker import scc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              edge_valid_i,
  input logic              edge_ready_o,
  input logic              last_edge_i,
  input logic              result_valid_o,
  input logic              result_ready_i,
  input logic [TotalW-1:0] node_total_o
);

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o)
    else $error("result word withdrawn before it was taken");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(edge_ready_o && result_valid_o))
    else $error("edge intake open while a result is offered");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_valid_i && edge_ready_o && last_edge_i |=> !edge_ready_o)
    else $error("edge intake still open after the last edge");

  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_ready_i |=> !result_valid_o)
    else $error("result offered again straight after a transfer");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> node_total_o <= TotalW'(MaxNodes))
    else $error("node total above node capacity");

endmodule

bind scc_condense_rank_histogram_top scc_checker u_scc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .edge_valid_i   (edge_valid_i),
  .edge_ready_o   (edge_ready_o),
  .last_edge_i    (last_edge_i),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .node_total_o   (node_total_o)
);
